### hdl/spcr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spcr_pkg
// Shared types, event codes and reply text tables of the ping responder.
// ----------------------------------------------------------------------------
package spcr_pkg;

    localparam int TIMEOUT_W = 20;

    localparam logic [1:0] OP_RX_BYTE  = 2'd0;
    localparam logic [1:0] OP_TX_READY = 2'd1;
    localparam logic [1:0] OP_TICK     = 2'd2;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 20'd100000;
    localparam logic [TIMEOUT_W-1:0] IDLE_MAX      = 20'hFFFFF;

    localparam int CMD_LEN = 5;
    localparam logic [4:0] OK_LEN  = 5'd14;
    localparam logic [4:0] ERR_LEN = 5'd26;

    localparam logic       KIND_OK  = 1'b0;
    localparam logic       KIND_ERR = 1'b1;
    localparam logic [7:0] CH_LF    = 8'h0A;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] rx_byte;
        logic       rx_error;
    } t_event;

    // line assembler to reply sequencer
    typedef struct packed {
        logic start;
        logic hit;
    } t_line_req;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       tx_last;
        logic       reply_pending;
    } t_result;

    function automatic logic [7:0] cmd_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = "P";
            3'd1:    c = "I";
            3'd2:    c = "N";
            3'd3:    c = "G";
            3'd4:    c = 8'h0D;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] ok_char(input logic [4:0] idx);
        logic [7:0] c;
        case (idx)
            5'd0:    c = "O";
            5'd1:    c = "K";
            5'd2:    c = ",";
            5'd3:    c = "P";
            5'd4:    c = "I";
            5'd5:    c = "N";
            5'd6:    c = "G";
            5'd7:    c = ",";
            5'd8:    c = "P";
            5'd9:    c = "O";
            5'd10:   c = "N";
            5'd11:   c = "G";
            5'd12:   c = 8'h0D;
            5'd13:   c = 8'h0A;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] err_char(input logic [4:0] idx);
        logic [7:0] c;
        case (idx)
            5'd0:    c = "E";
            5'd1:    c = "R";
            5'd2:    c = "R";
            5'd3:    c = ",";
            5'd4:    c = "U";
            5'd5:    c = "A";
            5'd6:    c = "R";
            5'd7:    c = "T";
            5'd8:    c = ",";
            5'd9:    c = "I";
            5'd10:   c = "N";
            5'd11:   c = "V";
            5'd12:   c = "A";
            5'd13:   c = "L";
            5'd14:   c = "I";
            5'd15:   c = "D";
            5'd16:   c = "_";
            5'd17:   c = "C";
            5'd18:   c = "O";
            5'd19:   c = "M";
            5'd20:   c = "M";
            5'd21:   c = "A";
            5'd22:   c = "N";
            5'd23:   c = "D";
            5'd24:   c = 8'h0D;
            5'd25:   c = 8'h0A;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

### hdl/spcr_line.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spcr_line
// Command line assembler: character count, discard mark, running prefix
// match against the ping command and the idle timeout counter.
// ----------------------------------------------------------------------------
module spcr_line
    import spcr_pkg::*;
#(
    parameter int LINE_BUFFER_SIZE = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  t_event               i_event,
    input  logic                 i_cfg_we,
    input  logic [TIMEOUT_W-1:0] i_cfg_data,
    output t_line_req            o_req
);

    localparam int CNT_W = $clog2(LINE_BUFFER_SIZE);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(LINE_BUFFER_SIZE - 1);
    localparam logic [CNT_W-1:0] CNT_CMD  = CNT_W'(CMD_LEN);

    logic [TIMEOUT_W-1:0] r_timeout;
    logic [CNT_W-1:0]     r_count, n_count;
    logic                 r_discard, n_discard;
    logic                 r_prefix, n_prefix;
    logic [TIMEOUT_W-1:0] r_idle, n_idle;
    logic                 w_busy;

    assign w_busy = (r_count != '0) || r_discard;

    always_comb begin
        n_count   = r_count;
        n_discard = r_discard;
        n_prefix  = r_prefix;
        n_idle    = r_idle;
        o_req     = '0;
        unique case (i_event.opcode)
            OP_RX_BYTE: begin
                n_idle = '0;
                if (i_event.rx_error) begin
                    n_count   = '0;
                    n_discard = 1'b1;
                    n_prefix  = 1'b1;
                end else if (i_event.rx_byte == CH_LF) begin
                    o_req.start = w_busy;
                    o_req.hit   = !r_discard && r_prefix && (r_count == CNT_CMD);
                    n_count     = '0;
                    n_discard   = 1'b0;
                    n_prefix    = 1'b1;
                end else if (!r_discard) begin
                    if ((r_count < CNT_FULL) && (i_event.rx_byte != 8'h00)) begin
                        if (!((r_count < CNT_CMD)
                              && (cmd_char(r_count[2:0]) == i_event.rx_byte))) begin
                            n_prefix = 1'b0;
                        end
                        n_count = r_count + 1'b1;
                    end else begin
                        n_discard = 1'b1;
                    end
                end
            end
            OP_TICK: begin
                if (r_idle != IDLE_MAX) begin
                    n_idle = r_idle + 1'b1;
                end
                // partial line dropped once idle long enough
                if (w_busy && (n_idle >= r_timeout)) begin
                    n_count   = '0;
                    n_discard = 1'b0;
                    n_prefix  = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
            r_count   <= '0;
            r_discard <= 1'b0;
            r_prefix  <= 1'b1;
            r_idle    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_timeout <= i_cfg_data;
            end
            if (i_step) begin
                r_count   <= n_count;
                r_discard <= n_discard;
                r_prefix  <= n_prefix;
                r_idle    <= n_idle;
            end
        end
    end

endmodule

### hdl/spcr_reply.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spcr_reply
// Reply sequencer: starts the ok or error reply on a finished line and hands
// out one reply character per transmitter-ready event.
// ----------------------------------------------------------------------------
module spcr_reply
    import spcr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_event    i_event,
    input  t_line_req i_req,
    output t_result   o_result
);

    logic       r_active, n_active;
    logic       r_kind, n_kind;
    logic [4:0] r_index, n_index;
    logic [4:0] w_len;
    logic [4:0] w_idx;
    logic [4:0] w_idx_nx;

    assign w_len    = (r_kind == KIND_OK) ? OK_LEN : ERR_LEN;
    assign w_idx    = (r_index >= w_len) ? (w_len - 5'd1) : r_index;
    assign w_idx_nx = w_idx + 5'd1;

    always_comb begin
        n_active = r_active;
        n_kind   = r_kind;
        n_index  = r_index;
        o_result = '0;
        unique case (i_event.opcode)
            OP_RX_BYTE: begin
                // a line finished while replying gets no answer
                if (i_req.start && !r_active) begin
                    n_kind   = i_req.hit ? KIND_OK : KIND_ERR;
                    n_index  = '0;
                    n_active = 1'b1;
                end
            end
            OP_TX_READY: begin
                if (r_active) begin
                    o_result.tx_valid = 1'b1;
                    o_result.tx_byte  = (r_kind == KIND_OK) ? ok_char(w_idx)
                                                            : err_char(w_idx);
                    n_index = w_idx_nx;
                    if (w_idx_nx >= w_len) begin
                        o_result.tx_last = 1'b1;
                        n_active         = 1'b0;
                        n_index          = '0;
                    end
                end
            end
            default: begin
            end
        endcase
        o_result.reply_pending = n_active;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_kind   <= KIND_OK;
            r_index  <= '0;
        end else if (i_step) begin
            r_active <= n_active;
            r_kind   <= n_kind;
            r_index  <= n_index;
        end
    end

endmodule

### hdl/serial_ping_command_responder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_ping_command_responder
// Answers serial command lines: "PING" CR LF gets the ok reply, any other
// non-empty or discarded line gets the error reply.
// ----------------------------------------------------------------------------
// Usage:
//   input channel (i_valid / o_ready) carries one event word: a received
//   byte with its error flag, a transmitter-ready slot or a 1 us tick.
//   output channel (o_valid / i_ready) returns exactly one result word per
//   event: the reply character sent on a ready slot (tx_valid, tx_byte,
//   tx_last) and whether a reply is still pending.
//   config channel (i_cfg_valid/o_cfg_ready), always ready: idle timeout in
//   ticks; the user writes it only while the block is idle (unchecked).
// Timing:
//   an event word is held in the input register and its result is registered
//   in the result register, which drives o_valid. one event per cycle is
//   sustained while i_ready stays high: the input register and the result
//   register form a two-stage pipeline.
// Reset: line empty, no reply pending, timeout back to 100000 ticks.
// Stall: while the result waits on i_ready the input register still takes
//   one more word; o_ready drops only when both stages are full.
// ----------------------------------------------------------------------------
module serial_ping_command_responder
    import spcr_pkg::*;
#(
    parameter int LINE_BUFFER_SIZE = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_opcode,
    input  logic [7:0]           i_rx_byte,
    input  logic                 i_rx_error,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_tx_valid,
    output logic [7:0]           o_tx_byte,
    output logic                 o_tx_last,
    output logic                 o_reply_pending,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [TIMEOUT_W-1:0] i_cfg_data
);

    logic      r_in_valid;
    t_event    r_event;
    logic      r_out_valid;
    t_result   r_result;
    logic      w_advance;
    t_line_req w_req;
    t_result   w_result;

    assign w_advance   = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready     = !r_in_valid || w_advance;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_event.opcode   <= i_opcode;
            r_event.rx_byte  <= i_rx_byte;
            r_event.rx_error <= i_rx_error;
        end
    end

    spcr_line #(
        .LINE_BUFFER_SIZE(LINE_BUFFER_SIZE)
    ) u_line (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (w_advance),
        .i_event    (r_event),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_req      (w_req)
    );

    spcr_reply u_reply (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_advance),
        .i_event  (r_event),
        .i_req    (w_req),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_result <= w_result;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_tx_valid      = r_result.tx_valid;
    assign o_tx_byte       = r_result.tx_byte;
    assign o_tx_last       = r_result.tx_last;
    assign o_reply_pending = r_result.reply_pending;

endmodule

### hdl/spcr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spcr_checker
// Port-level checks of the result stream of the ping responder.
// ----------------------------------------------------------------------------
module spcr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic       o_tx_valid,
    input logic [7:0] o_tx_byte,
    input logic       o_tx_last,
    input logic       o_reply_pending
);

    // stalled word stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_tx_byte) && $stable(o_tx_last))
        else $error("result word changed while stalled");

    // idle slot carries no character
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_tx_valid |-> o_tx_byte == 8'h00 && !o_tx_last)
        else $error("character without tx_valid");

    // last character ends the reply
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_tx_last |-> o_tx_valid && !o_reply_pending)
        else $error("reply still pending after last character");

    // a middle character leaves the reply pending
    a_mid_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_tx_valid && !o_tx_last |-> o_reply_pending)
        else $error("reply ended without last character");

    // every reply ends in line feed
    a_last_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_tx_last |-> o_tx_byte == 8'h0A)
        else $error("last character is not a line feed");

endmodule

bind serial_ping_command_responder spcr_checker u_spcr_checker (.*);
